// File: sv/epf_pkg.sv
// Shared types, codes and constants of the escaped packet framer.
`default_nettype none

package epf_pkg;

    localparam int MAX_PAYLOAD_DEF = 128;

    localparam logic [7:0] FIRST_PACKET_ID = 8'd4;

    localparam logic [7:0] START_BYTE_RST = 8'd2;
    localparam logic [7:0] END_BYTE_RST = 8'd3;
    localparam logic [7:0] ESCAPE_BYTE_RST = 8'd16;
    localparam logic [2:0] REPEAT_COUNT_RST = 3'd3;

    localparam logic [1:0] CFG_START_BYTE = 2'd0;
    localparam logic [1:0] CFG_END_BYTE = 2'd1;
    localparam logic [1:0] CFG_ESCAPE_BYTE = 2'd2;
    localparam logic [1:0] CFG_REPEAT_COUNT = 2'd3;

    localparam logic REQ_LOAD = 1'b0;
    localparam logic REQ_TICK = 1'b1;

    localparam logic [1:0] KIND_BYTE = 2'd0;
    localparam logic [1:0] KIND_REJECT = 2'd1;
    localparam logic [1:0] KIND_DROP = 2'd2;

    typedef struct packed {
        logic       req_type;
        logic [7:0] payload_byte;
        logic       payload_last;
    } in_item_t;

    typedef struct packed {
        logic [7:0] tx_byte;
        logic [1:0] kind;
        logic       frame_end;
        logic       packet_done;
    } out_item_t;

    typedef enum logic [2:0] {
        SRC_ZERO,
        SRC_START,
        SRC_END,
        SRC_ESCAPE,
        SRC_CAND
    } out_src_t;

    typedef enum logic [1:0] {
        CAND_ID,
        CAND_LEN,
        CAND_DATA
    } cand_sel_t;

    typedef struct packed {
        logic       capture;
        logic       store_write;
        logic       count_clear;
        logic       packet_inc;
        logic       read_clear;
        logic       read_inc;
        cand_sel_t  cand_sel;
        logic       out_load;
        out_src_t   out_src;
        logic [1:0] out_kind;
        logic       out_frame_end;
        logic       out_packet_done;
    } ctrl_cmd_t;

    typedef struct packed {
        logic       req_type;
        logic       payload_last;
        logic       count_full;
        logic       count_zero;
        logic       cand_special;
        logic       read_last;
        logic       out_busy;
        logic [2:0] repeat_count;
    } dp_status_t;

endpackage

`default_nettype wire

// File: sv/escaped_packet_framer_tx.sv
// Top level of the escaped packet framer, transmit side.
//
//   Channel   Direction  Handshake              Payload
//   in        input      in_valid / in_ready    in_data   (epf_pkg::in_item_t)
//   out       output     out_valid / out_ready  out_data  (epf_pkg::out_item_t)
//   cfg       input      cfg_write              cfg_index, cfg_data
//
// A request is accepted in the wait state and then handled in the execute state, in which
// the registered read of the payload buffer is used; the next request can be
// accepted in the cycle after execute. A request that produces a result waits in
// execute while the output register still holds an untaken result.
// Reset needs no clearing pass; payload buffer entries are only read once written.
`default_nettype none

module escaped_packet_framer_tx #(
    parameter int MAX_PAYLOAD = epf_pkg::MAX_PAYLOAD_DEF
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               cfg_write,
    input  wire logic [1:0]         cfg_index,
    input  wire logic [7:0]         cfg_data,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire epf_pkg::in_item_t  in_data,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output epf_pkg::out_item_t      out_data
);

    import epf_pkg::*;

    ctrl_cmd_t  cmd;
    dp_status_t status;

    epf_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    epf_dp #(
        .MAX_PAYLOAD (MAX_PAYLOAD)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_data   (in_data),
        .out_ready (out_ready),
        .out_valid (out_valid),
        .out_data  (out_data),
        .cmd       (cmd),
        .status    (status)
    );

endmodule

`default_nettype wire

// File: sv/epf_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module epf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 128,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// File: sv/epf_dp.sv
// Datapath: registers, payload buffer, counters, byte selection and result register.
`default_nettype none

module epf_dp #(
    parameter int MAX_PAYLOAD = epf_pkg::MAX_PAYLOAD_DEF
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               cfg_write,
    input  wire logic [1:0]         cfg_index,
    input  wire logic [7:0]         cfg_data,
    input  wire epf_pkg::in_item_t  in_data,
    input  wire logic               out_ready,
    output logic                    out_valid,
    output epf_pkg::out_item_t      out_data,
    input  wire epf_pkg::ctrl_cmd_t cmd,
    output epf_pkg::dp_status_t     status
);

    import epf_pkg::*;

    localparam int AW = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;
    localparam logic [7:0] MAX_COUNT = 8'(MAX_PAYLOAD);

    logic [7:0] start_byte_reg;
    logic [7:0] end_byte_reg;
    logic [7:0] escape_byte_reg;
    logic [2:0] repeat_count_reg;

    logic [7:0] count_reg, count_next;
    logic [7:0] packet_reg, packet_next;
    logic [7:0] read_index_reg, read_index_next;
    logic       out_valid_reg, out_valid_next;

    in_item_t   in_reg;
    out_item_t  out_reg;
    logic [7:0] store_rdata;
    logic [7:0] cand_byte;
    logic [7:0] out_byte;
    logic [8:0] read_plus;

    epf_ram #(
        .WIDTH (8),
        .DEPTH (MAX_PAYLOAD)
    ) u_store (
        .clk   (clk),
        .we    (cmd.store_write),
        .waddr (count_reg[AW-1:0]),
        .wdata (in_reg.payload_byte),
        .raddr (read_index_reg[AW-1:0]),
        .rdata (store_rdata)
    );

    always_comb
    begin
        case (cmd.cand_sel)
            CAND_ID:   cand_byte = packet_reg;
            CAND_LEN:  cand_byte = count_reg;
            CAND_DATA: cand_byte = store_rdata;
            default:   cand_byte = packet_reg;
        endcase

        case (cmd.out_src)
            SRC_START:  out_byte = start_byte_reg;
            SRC_END:    out_byte = end_byte_reg;
            SRC_ESCAPE: out_byte = escape_byte_reg;
            SRC_CAND:   out_byte = cand_byte;
            default:    out_byte = 8'd0;
        endcase
    end

    assign read_plus = {1'b0, read_index_reg} + 9'd1;

    always_comb
    begin
        count_next = count_reg;
        if (cmd.count_clear)
        begin
            count_next = 8'd0;
        end
        else if (cmd.store_write)
        begin
            count_next = count_reg + 8'd1;
        end

        packet_next = cmd.packet_inc ? packet_reg + 8'd1 : packet_reg;

        read_index_next = read_index_reg;
        if (cmd.read_clear)
        begin
            read_index_next = 8'd0;
        end
        else if (cmd.read_inc)
        begin
            read_index_next = read_plus[7:0];
        end

        out_valid_next = out_valid_reg;
        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_byte_reg   <= START_BYTE_RST;
            end_byte_reg     <= END_BYTE_RST;
            escape_byte_reg  <= ESCAPE_BYTE_RST;
            repeat_count_reg <= REPEAT_COUNT_RST;
            count_reg        <= 8'd0;
            packet_reg       <= FIRST_PACKET_ID;
            read_index_reg   <= 8'd0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            if (cfg_write)
            begin
                case (cfg_index)
                    CFG_START_BYTE:   start_byte_reg   <= cfg_data;
                    CFG_END_BYTE:     end_byte_reg     <= cfg_data;
                    CFG_ESCAPE_BYTE:  escape_byte_reg  <= cfg_data;
                    CFG_REPEAT_COUNT: repeat_count_reg <= cfg_data[2:0];
                    default:          ;
                endcase
            end
            count_reg      <= count_next;
            packet_reg     <= packet_next;
            read_index_reg <= read_index_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            in_reg <= in_data;
        end
        if (cmd.out_load)
        begin
            out_reg.tx_byte     <= out_byte;
            out_reg.kind        <= cmd.out_kind;
            out_reg.frame_end   <= cmd.out_frame_end;
            out_reg.packet_done <= cmd.out_packet_done;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    always_comb
    begin
        status.req_type     = in_reg.req_type;
        status.payload_last = in_reg.payload_last;
        status.count_full   = (count_reg >= MAX_COUNT);
        status.count_zero   = (count_reg == 8'd0);
        status.cand_special = (cand_byte == start_byte_reg) || (cand_byte == end_byte_reg)
                              || (cand_byte == escape_byte_reg);
        status.read_last    = (read_plus >= {1'b0, count_reg});
        status.out_busy     = out_valid_reg && !out_ready;
        status.repeat_count = repeat_count_reg;
    end

endmodule

`default_nettype wire

// File: sv/epf_ctrl.sv
// Controller: request sequencing and framing state machine.
`default_nettype none

module epf_ctrl (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    output logic                     in_ready,
    input  wire epf_pkg::dp_status_t status,
    output epf_pkg::ctrl_cmd_t       cmd
);

    import epf_pkg::*;

    typedef enum logic {
        S_WAIT,
        S_EXEC
    } seq_t;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_START,
        PH_ID,
        PH_LEN,
        PH_DATA,
        PH_END
    } phase_t;

    seq_t   seq_reg, seq_next;
    phase_t phase_reg, phase_next;
    logic   esc_reg, esc_next;
    logic [2:0] copies_reg, copies_next;

    logic [2:0] copies_plus;
    logic [2:0] need;
    logic       last_copy;
    logic       emit;

    assign copies_plus = copies_reg + 3'd1;
    assign need        = (status.repeat_count == 3'd0) ? 3'd1 : status.repeat_count;
    assign last_copy   = (copies_plus >= need) || (copies_plus == 3'd0);
    assign in_ready    = (seq_reg == S_WAIT);

    always_comb
    begin
        seq_next    = seq_reg;
        phase_next  = phase_reg;
        esc_next    = esc_reg;
        copies_next = copies_reg;

        cmd                 = '0;
        cmd.capture         = in_valid && in_ready;
        cmd.cand_sel        = CAND_ID;
        cmd.out_src         = SRC_ZERO;
        cmd.out_kind        = KIND_BYTE;

        case (phase_reg)
            PH_LEN:  cmd.cand_sel = CAND_LEN;
            PH_DATA: cmd.cand_sel = CAND_DATA;
            default: cmd.cand_sel = CAND_ID;
        endcase

        // Does this request produce a result?
        emit = 1'b0;
        if (status.req_type == REQ_LOAD)
        begin
            emit = (phase_reg != PH_IDLE) || status.count_full;
        end
        else
        begin
            emit = (phase_reg != PH_IDLE);
        end

        case (seq_reg)
            S_WAIT:
            begin
                if (in_valid)
                begin
                    seq_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                // A result can only be produced once the output register is free.
                if (!(emit && status.out_busy))
                begin
                    seq_next     = S_WAIT;
                    cmd.out_load = emit;
                    if (status.req_type == REQ_LOAD)
                    begin
                        if (phase_reg != PH_IDLE)
                        begin
                            cmd.out_kind = KIND_REJECT;
                        end
                        else
                        begin
                            if (status.count_full)
                            begin
                                cmd.out_kind = KIND_DROP;
                            end
                            else
                            begin
                                cmd.store_write = 1'b1;
                            end
                            if (status.payload_last)
                            begin
                                phase_next     = PH_START;
                                esc_next       = 1'b0;
                                copies_next    = 3'd0;
                                cmd.read_clear = 1'b1;
                            end
                        end
                    end
                    else
                    begin
                        case (phase_reg)
                            PH_START:
                            begin
                                cmd.out_src = SRC_START;
                                esc_next    = 1'b0;
                                phase_next  = PH_ID;
                            end
                            PH_ID, PH_LEN, PH_DATA:
                            begin
                                if (!esc_reg && status.cand_special)
                                begin
                                    cmd.out_src = SRC_ESCAPE;
                                    esc_next    = 1'b1;
                                end
                                else
                                begin
                                    cmd.out_src = SRC_CAND;
                                    esc_next    = 1'b0;
                                    if (phase_reg == PH_ID)
                                    begin
                                        phase_next = PH_LEN;
                                    end
                                    else if (phase_reg == PH_LEN)
                                    begin
                                        cmd.read_clear = 1'b1;
                                        phase_next = status.count_zero ? PH_END : PH_DATA;
                                    end
                                    else
                                    begin
                                        cmd.read_inc = 1'b1;
                                        if (status.read_last)
                                        begin
                                            phase_next = PH_END;
                                        end
                                    end
                                end
                            end
                            PH_END:
                            begin
                                cmd.out_src       = SRC_END;
                                cmd.out_frame_end = 1'b1;
                                cmd.read_clear    = 1'b1;
                                esc_next          = 1'b0;
                                if (last_copy)
                                begin
                                    cmd.out_packet_done = 1'b1;
                                    cmd.packet_inc      = 1'b1;
                                    cmd.count_clear     = 1'b1;
                                    copies_next         = 3'd0;
                                    phase_next          = PH_IDLE;
                                end
                                else
                                begin
                                    copies_next = copies_plus;
                                    phase_next  = PH_START;
                                end
                            end
                            default:
                            begin
                                phase_next = PH_IDLE;
                            end
                        endcase
                    end
                end
            end
            default:
            begin
                seq_next = S_WAIT;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seq_reg    <= S_WAIT;
            phase_reg  <= PH_IDLE;
            esc_reg    <= 1'b0;
            copies_reg <= 3'd0;
        end
        else
        begin
            seq_reg    <= seq_next;
            phase_reg  <= phase_next;
            esc_reg    <= esc_next;
            copies_reg <= copies_next;
        end
    end

endmodule

`default_nettype wire

// File: sv/epf_checker.sv
// Port-level checker for the framer and its bind to the top level.
`default_nettype none

module epf_checker (
    input wire logic               clk,
    input wire logic               rst_n,
    input wire logic               in_valid,
    input wire logic               in_ready,
    input wire logic               out_valid,
    input wire logic               out_ready,
    input wire epf_pkg::out_item_t out_data
);

    import epf_pkg::*;

    // A held result must not change until it is taken.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("result changed while stalled");

    // Every request needs an execute cycle before the next one is taken.
    a_no_back_to_back: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("request accepted in execute cycle");

    // Rejections and drops carry no byte and no framing flags.
    a_flag_clean: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (out_data.kind != KIND_BYTE) |->
            (out_data.tx_byte == 8'd0) && !out_data.frame_end && !out_data.packet_done)
        else $error("non-byte result carries data");

    // The end of a packet is always the end of a copy.
    a_done_is_end: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.packet_done |-> out_data.frame_end
            && (out_data.kind == KIND_BYTE))
        else $error("packet end without frame end");

    a_kind_legal: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_data.kind == KIND_BYTE) || (out_data.kind == KIND_REJECT)
            || (out_data.kind == KIND_DROP))
        else $error("illegal result kind");

endmodule

bind escaped_packet_framer_tx epf_checker u_epf_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
);

`default_nettype wire
